@@ hdl/shortest_remaining_ready_queue_top_assert.svh @@
// ----------------------------------------------------------------------------
// Ready queue assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_READY_QUEUE_TOP_ASSERT_SVH
`define SHORTEST_REMAINING_READY_QUEUE_TOP_ASSERT_SVH

// property checked only out of reset
`define SRRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SRRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/srrq_pkg.sv @@
// ----------------------------------------------------------------------------
// Ready queue package
// Sizes, codes and controller command type shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srrq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 8;
  localparam int KEY_W = 16;

  // request kinds
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // run the latched request and load the result register
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/srrq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ready queue controller
// Two-state sequencer: take a request, then run it once the result register
// is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module srrq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output srrq_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/srrq_dpath.sv @@
// ----------------------------------------------------------------------------
// Ready queue datapath
// Sorted shift-register array of id/key cells, request register and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shortest_remaining_ready_queue_top_assert.svh"

module srrq_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire srrq_pkg::cmd_t                cmd,
  input  wire logic                          in_act,
  input  wire logic [srrq_pkg::ID_W-1:0]     in_id,
  input  wire logic [srrq_pkg::KEY_W-1:0]    in_key,
  output logic                               res_valid,
  output logic [srrq_pkg::ID_W-1:0]          res_id,
  output logic [srrq_pkg::KEY_W-1:0]         res_key,
  output logic                               res_empty,
  output logic                               res_full,
  output logic [1:0]                         res_err
);

  localparam int DEPTH = srrq_pkg::DEPTH;
  localparam int CNT_W = srrq_pkg::CNT_W;
  localparam int ID_W  = srrq_pkg::ID_W;
  localparam int KEY_W = srrq_pkg::KEY_W;

  // request register
  logic             req_act_r;
  logic [ID_W-1:0]  req_id_r;
  logic [KEY_W-1:0] req_key_r;

  // queue cells and fill count
  logic [ID_W-1:0]  ids_r  [DEPTH];
  logic [KEY_W-1:0] keys_r [DEPTH];
  logic [ID_W-1:0]  ids_nxt  [DEPTH];
  logic [KEY_W-1:0] keys_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  // result register
  logic             res_valid_r, res_valid_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  logic             res_empty_r, res_empty_nxt;
  logic             res_full_r, res_full_nxt;
  logic [1:0]       res_err_r, res_err_nxt;

  logic             q_full, q_empty;
  logic [DEPTH-1:0] le;       // cell holds a key at or below the new key
  logic [DEPTH-1:0] prev_le;  // cell below it does (head counts as yes)
  logic             pop_run;  // pop running on a non-empty queue

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign pop_run = cmd.exec && (req_act_r == srrq_pkg::ACT_POP) && !q_empty;

  // per-cell compare against the new key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (count_r > CNT_W'(i)) && (keys_r[i] <= req_key_r);
    end
    prev_le[0] = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      prev_le[i] = le[i-1];
    end
  end

  // cell update, count and result
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ids_nxt[i]  = ids_r[i];
      keys_nxt[i] = keys_r[i];
    end
    count_nxt     = count_r;
    res_valid_nxt = res_valid_r;
    res_id_nxt    = res_id_r;
    res_key_nxt   = res_key_r;
    res_empty_nxt = res_empty_r;
    res_full_nxt  = res_full_r;
    res_err_nxt   = res_err_r;
    if (cmd.exec) begin
      res_valid_nxt = 1'b0;
      res_id_nxt    = '0;
      res_key_nxt   = '0;
      res_err_nxt   = srrq_pkg::ERR_NONE;
      if (req_act_r == srrq_pkg::ACT_INSERT) begin
        if (q_full) begin
          res_err_nxt = srrq_pkg::ERR_FULL;
        end else begin
          // keep cells at or below the key, drop the new entry in, shift the rest up
          for (int i = 0; i < DEPTH; i++) begin
            if (!le[i] && prev_le[i]) begin
              ids_nxt[i]  = req_id_r;
              keys_nxt[i] = req_key_r;
            end
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (!le[i] && !prev_le[i]) begin
              ids_nxt[i]  = ids_r[i-1];
              keys_nxt[i] = keys_r[i-1];
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (q_empty) begin
          res_err_nxt = srrq_pkg::ERR_EMPTY;
        end else begin
          // hand out the head and shift everything down
          res_valid_nxt = 1'b1;
          res_id_nxt    = ids_r[0];
          res_key_nxt   = keys_r[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            ids_nxt[i]  = ids_r[i+1];
            keys_nxt[i] = keys_r[i+1];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      res_empty_nxt = (count_nxt == '0);
      res_full_nxt  = (count_nxt == CNT_W'(DEPTH));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_act_r <= in_act;
      req_id_r  <= in_id;
      req_key_r <= in_key;
    end
    for (int i = 0; i < DEPTH; i++) begin
      ids_r[i]  <= ids_nxt[i];
      keys_r[i] <= keys_nxt[i];
    end
    res_valid_r <= res_valid_nxt;
    res_id_r    <= res_id_nxt;
    res_key_r   <= res_key_nxt;
    res_empty_r <= res_empty_nxt;
    res_full_r  <= res_full_nxt;
    res_err_r   <= res_err_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_id    = res_id_r;
  assign res_key   = res_key_r;
  assign res_empty = res_empty_r;
  assign res_full  = res_full_r;
  assign res_err   = res_err_r;

  // checks
  `SRRQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `SRRQ_ASSERT(a_pop_count, pop_run |=> count_r == $past(count_r) - 1'b1, "pop count off")
  `SRRQ_ASSERT(a_idle_count, !cmd.exec |=> $stable(count_r), "count moved without a request")
  `SRRQ_ASSERT_ALWAYS(a_cmd_excl, !(cmd.capture && cmd.exec), "capture and run in one cycle")

endmodule

`default_nettype wire

@@ hdl/shortest_remaining_ready_queue_top.sv @@
// ----------------------------------------------------------------------------
// Shortest remaining time ready queue
// Stable min priority queue of process ids sorted by remaining burst time.
//
// channel  dir  tdata                                         tuser
// in_      in   proc_id[7:0] remaining_time[23:8]             action
// out_     out  out_valid[0] out_id[8:1] out_remaining[24:9]  -
//               is_empty[25] is_full[26] error[28:27]
//
// Each request is first latched in the request register, then run on the sorted
// cell array, which compares every cell with the new key in parallel.
// A result sits in an output register; the next request is latched while it
// waits, and is run only once that register is free or being drained.
// Reset (rst_n low, synchronous) empties the queue; cell contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_remaining_ready_queue_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // proc_id, remaining_time
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // out_valid, out_id, out_remaining,
                                       // is_empty, is_full, error
);

  srrq_pkg::cmd_t                  cmd;
  logic                            res_valid;
  logic [srrq_pkg::ID_W-1:0]       res_id;
  logic [srrq_pkg::KEY_W-1:0]      res_key;
  logic                            res_empty;
  logic                            res_full;
  logic [1:0]                      res_err;

  srrq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  srrq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_act    (in_tuser),
    .in_id     (in_tdata[7:0]),
    .in_key    (in_tdata[23:8]),
    .res_valid (res_valid),
    .res_id    (res_id),
    .res_key   (res_key),
    .res_empty (res_empty),
    .res_full  (res_full),
    .res_err   (res_err)
  );

  // pack the result fields
  assign out_tdata = {3'b000, res_err, res_full, res_empty, res_key, res_id, res_valid};

endmodule

`default_nettype wire

@@ tb/ready_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue result checker
// Watches the request and result streams of the ready queue. Every accepted
// request runs through a sorted-array model of the queue. Every accepted
// result is compared, field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------

module ready_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // proc_id, remaining_time
  input  logic        in_tuser,   // action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // out_valid, out_id, out_remaining,
                                  // is_empty, is_full, error
  output int          fail_count,
  output int          pending
);

  // one result word, members listed from the top bit down
  typedef struct packed {
    logic [1:0]                 err;
    logic                       full;
    logic                       empty;
    logic [srrq_pkg::KEY_W-1:0] key;
    logic [srrq_pkg::ID_W-1:0]  id;
    logic                       valid;
  } pop_result_t;

  // model of the sorted cell array, smallest key at index 0
  logic [srrq_pkg::ID_W-1:0]  sorted_ids  [srrq_pkg::DEPTH];
  logic [srrq_pkg::KEY_W-1:0] sorted_keys [srrq_pkg::DEPTH];
  int                         occupancy;

  pop_result_t awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    occupancy  = 0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input int want, input int got);
    fail_count++;
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // work out the result of one request and update the model
  task automatic apply_queue_request(input logic act,
                                     input logic [srrq_pkg::ID_W-1:0] id,
                                     input logic [srrq_pkg::KEY_W-1:0] key);
    pop_result_t res;
    int          pos;
    res = '0;
    res.err = srrq_pkg::ERR_NONE;
    if (act == srrq_pkg::ACT_INSERT) begin
      if (occupancy >= srrq_pkg::DEPTH) begin
        res.err = srrq_pkg::ERR_FULL;
      end else begin
        // new entry goes behind every entry with an equal or smaller key
        pos = 0;
        while (pos < occupancy && sorted_keys[pos] <= key) pos++;
        for (int i = occupancy; i > pos; i--) begin
          sorted_ids[i]  = sorted_ids[i-1];
          sorted_keys[i] = sorted_keys[i-1];
        end
        sorted_ids[pos]  = id;
        sorted_keys[pos] = key;
        occupancy++;
      end
    end else begin
      if (occupancy == 0) begin
        res.err = srrq_pkg::ERR_EMPTY;
      end else begin
        res.valid = 1'b1;
        res.id    = sorted_ids[0];
        res.key   = sorted_keys[0];
        for (int i = 1; i < occupancy; i++) begin
          sorted_ids[i-1]  = sorted_ids[i];
          sorted_keys[i-1] = sorted_keys[i];
        end
        occupancy--;
      end
    end
    res.empty = (occupancy == 0);
    res.full  = (occupancy >= srrq_pkg::DEPTH);
    awaited_results.push_back(res);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    pop_result_t want;
    pop_result_t got;
    if (!rst_n) begin
      occupancy = 0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[28:0];
        if (awaited_results.size() == 0) begin
          report_mismatch("result with none awaited", 0, out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (got.valid !== want.valid) report_mismatch("out_valid", want.valid, got.valid);
          if (got.id    !== want.id)    report_mismatch("out_id", want.id, got.id);
          if (got.key   !== want.key)   report_mismatch("out_remaining", want.key, got.key);
          if (got.empty !== want.empty) report_mismatch("is_empty", want.empty, got.empty);
          if (got.full  !== want.full)  report_mismatch("is_full", want.full, got.full);
          if (got.err   !== want.err)   report_mismatch("error", want.err, got.err);
          if (out_tdata[31:29] !== 3'b000)
            report_mismatch("padding bits", 0, out_tdata[31:29]);
        end
      end
      if (in_tvalid && in_tready)
        apply_queue_request(in_tuser, in_tdata[7:0], in_tdata[23:8]);
    end
    pending = awaited_results.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue testbench
// Drives insert and pop requests into the shortest remaining time ready
// queue: a directed opening over key extremes, ties, full and empty cases,
// then random bursts that swing the queue between empty and full under
// changing backpressure. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_PERIOD  = 3000;
  localparam int HOLD_LEN     = 120;
  localparam int PHASE_ITEMS  = 500;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // proc_id, remaining_time
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_valid, out_id, out_remaining, is_empty, is_full, error

  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int recv_cycle;

  shortest_remaining_ready_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ready_queue_checker queue_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off now and then
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (recv_cycle % HOLD_PERIOD == HOLD_PERIOD - 1) begin
      out_tready <= 1'b0;
      hold_left = HOLD_LEN;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    recv_cycle++;
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic act, input logic [srrq_pkg::ID_W-1:0] id,
                              input logic [srrq_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {key, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // random bursts leaning toward inserts, pops or neither
  task automatic run_random_bursts(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int burst_len;
    int insert_pct;
    logic [srrq_pkg::KEY_W-1:0] key;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(40, 1);
      case ($urandom_range(2))
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      for (int i = 0; i < burst_len && sent < n_items; i++) begin
        case ($urandom_range(3))
          0:       key = 16'($urandom_range(7));        // dense ties
          1:       key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: key = 16'($urandom_range(65535));
        endcase
        send_request(($urandom_range(99) < insert_pct) ? srrq_pkg::ACT_INSERT
                                                       : srrq_pkg::ACT_POP,
                     8'($urandom_range(255)), key);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tuser      = srrq_pkg::ACT_INSERT;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_cycle    = 0;
    // receiver starts held off so the opening requests back up
    hold_left     = 60;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pop from an empty queue
    send_request(srrq_pkg::ACT_POP, 8'hFF, 16'hFFFF);
    // key and id extremes, ties at both ends and in the middle
    send_request(srrq_pkg::ACT_INSERT, 8'h00, 16'h0000);
    send_request(srrq_pkg::ACT_INSERT, 8'hFF, 16'hFFFF);
    send_request(srrq_pkg::ACT_INSERT, 8'h5A, 16'hFFFF);
    send_request(srrq_pkg::ACT_INSERT, 8'hA5, 16'h0000);
    send_request(srrq_pkg::ACT_INSERT, 8'h3C, 16'h8000);
    send_request(srrq_pkg::ACT_INSERT, 8'hC3, 16'h8000);
    // fill up with equal keys
    for (int i = 0; i < srrq_pkg::DEPTH - 6; i++)
      send_request(srrq_pkg::ACT_INSERT, 8'(8'h10 + i), 16'h1234);
    // insert into a full queue is dropped
    send_request(srrq_pkg::ACT_INSERT, 8'h77, 16'h0001);
    // pops return the head in key order, arrival order among ties
    repeat (3) send_request(srrq_pkg::ACT_POP, 8'h00, 16'h0000);

    run_random_bursts(PHASE_ITEMS, 7, 81);
    run_random_bursts(PHASE_ITEMS, 81, 7);
    run_random_bursts(PHASE_ITEMS, 0, 0);
    in_tvalid <= 1'b0;

    // drain, then idle before the verdict
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/srrq_pkg.sv
hdl/srrq_ctrl.sv
hdl/srrq_dpath.sv
hdl/shortest_remaining_ready_queue_top.sv
tb/ready_queue_checker.sv
tb/testbench.sv
